// ----- hdl/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and field widths for the Toffoli cascade evaluator.
// ----------------------------------------------------------------------------
package tce_pkg;

	localparam int WORD_W = 16;
	localparam int SLOT_W = 6;
	localparam int TGT_W  = 4;
	localparam int CFG_W  = 7;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_EVAL = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [SLOT_W-1:0]  slot;
		logic [TGT_W-1:0]   target;
		logic [WORD_W-1:0]  controls;
		logic [WORD_W-1:0]  word;
	} item_t;

endpackage

// ----- hdl/tce_stage.sv -----
// ----------------------------------------------------------------------------
// tce_stage
// One cascade position: holds the gate of slot IDX, captures it when a
// load word passes, and applies it to evaluate words if IDX < active_gates.
// ----------------------------------------------------------------------------
module tce_stage import tce_pkg::*; #(
	parameter int IDX       = 0,
	parameter int NUM_LINES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [CFG_W-1:0] active_gates,
	input  logic             in_valid,
	input  item_t            in_item,
	output logic             out_valid,
	output item_t            out_item
);

	localparam logic [WORD_W-1:0] LINE_MASK = (NUM_LINES >= WORD_W) ? {WORD_W{1'b1}} :
		WORD_W'((64'd1 << NUM_LINES) - 64'd1);

	logic              valid_s1;
	item_t             item_s1;
	logic [TGT_W-1:0]  gate_tgt_q;
	logic [WORD_W-1:0] gate_ctl_q;
	logic              gate_on;
	logic              fire;
	logic              load_hit;
	item_t             item_d;

	always_comb begin
		gate_on  = IDX < int'(active_gates);
		fire     = (in_item.mode == MODE_EVAL) && gate_on &&
			((in_item.word & gate_ctl_q) == gate_ctl_q);
		load_hit = in_valid && (in_item.mode == MODE_LOAD) && (int'(in_item.slot) == IDX);
		item_d   = in_item;
		if (fire) begin
			item_d.word = (in_item.word ^ (WORD_W'(1) << gate_tgt_q)) & LINE_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item_d;
			if (load_hit) begin
				gate_tgt_q <= in_item.target;
				gate_ctl_q <= in_item.controls;
			end
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

// ----- hdl/toffoli_cascade_evaluator.sv -----
// ----------------------------------------------------------------------------
// toffoli_cascade_evaluator
// Cascade of multiple-controlled Toffoli gates, one pipeline stage per gate
// slot; load words program slots in flight, evaluate words run the cascade.
// ----------------------------------------------------------------------------
// channel   dir  signals                    content
// s_*       in   tvalid tready tdata tuser  load or evaluate word
// m_*       out  tvalid tready tdata        result word
// cfg_*     in   wr_en wr_data              active_gates
//
// One word enters per cycle while s_tready is high; an evaluate word passes
// one stage per gate slot plus the output register before its result leaves.
// Load words travel the same pipe and update their slot's stage on the way,
// so every word sees the gates written before it. Reset clears valid bits
// and active_gates; gate slots hold garbage until loaded. A held result
// stalls the pipe only when the last stage also holds a result.
// ----------------------------------------------------------------------------
module toffoli_cascade_evaluator import tce_pkg::*; #(
	parameter int NUM_LINES = 16,
	parameter int MAX_GATES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // gate_slot, target_line, control_mask, data_word
	input  logic              s_tuser,   // mode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [WORD_W-1:0] m_tdata,   // result_word
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data
);

	localparam logic [WORD_W-1:0] LINE_MASK = (NUM_LINES >= WORD_W) ? {WORD_W{1'b1}} :
		WORD_W'((64'd1 << NUM_LINES) - 64'd1);

	logic [CFG_W-1:0]  active_gates_q;
	logic              en;
	logic              produce;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_data_q;
	logic              pipe_valid [MAX_GATES+1];
	item_t             pipe_item  [MAX_GATES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_gates_q <= '0;
		end else if (cfg_wr_en) begin
			active_gates_q <= cfg_wr_data;
		end
	end

	always_comb begin
		pipe_valid[0]          = s_tvalid;
		pipe_item[0].mode      = mode_t'(s_tuser);
		pipe_item[0].slot      = s_tdata[5:0];
		pipe_item[0].target    = s_tdata[9:6];
		pipe_item[0].controls  = s_tdata[25:10];
		pipe_item[0].word      = s_tdata[41:26] & LINE_MASK;
	end

	for (genvar g = 0; g < MAX_GATES; g++) begin : g_stage
		tce_stage #(
			.IDX       (g),
			.NUM_LINES (NUM_LINES)
		) u_stage (
			.clk          (clk),
			.arst_n       (arst_n),
			.en           (en),
			.active_gates (active_gates_q),
			.in_valid     (pipe_valid[g]),
			.in_item      (pipe_item[g]),
			.out_valid    (pipe_valid[g+1]),
			.out_item     (pipe_item[g+1])
		);
	end

	assign produce  = pipe_valid[MAX_GATES] && (pipe_item[MAX_GATES].mode == MODE_EVAL);
	assign en       = !(out_valid_q && !m_tready && produce);
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= produce;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= pipe_item[MAX_GATES].word;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && produce) |-> !s_tready)
		else $error("input accepted while finished result is blocked");

	a_lines_beyond_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata & ~LINE_MASK) == '0))
		else $error("result carries bits beyond the circuit lines");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(produce && (!m_tvalid || m_tready)) |=> m_tvalid)
		else $error("result from last stage was dropped");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pipe_valid[MAX_GATES] && pipe_item[MAX_GATES].mode == MODE_LOAD && !m_tvalid)
		|=> !m_tvalid)
		else $error("load word produced a result");

endmodule

// ----- test/cascade_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascade_checker
// Watches the input, output and config channels of the Toffoli cascade
// evaluator, keeps its own gate table, predicts each result word and
// compares it in order with what the block sends.
// ----------------------------------------------------------------------------
module cascade_checker import tce_pkg::*; #(
	parameter int MAX_GATES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [47:0]       s_tdata,   // gate_slot, target_line, control_mask, data_word
	input  logic              s_tuser,   // mode
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [WORD_W-1:0] m_tdata,   // result_word
	input  logic              cfg_wr_en,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	output int                mismatch_count,
	output int                results_owed
);

	logic [TGT_W-1:0]  gate_target [MAX_GATES];
	logic [WORD_W-1:0] gate_controls [MAX_GATES];
	logic [CFG_W-1:0]  gate_count;
	logic [WORD_W-1:0] owed_words [$];
	int                errors;

	function automatic logic [WORD_W-1:0] run_cascade(input logic [WORD_W-1:0] lines);
		int depth;
		depth = (gate_count > MAX_GATES) ? MAX_GATES : int'(gate_count);
		for (int g = 0; g < depth; g++)
			if ((lines & gate_controls[g]) == gate_controls[g])
				lines[gate_target[g]] = ~lines[gate_target[g]];
		return lines;
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_words.delete();
			gate_count = '0;
			errors = 0;
			mismatch_count <= 0;
			results_owed <= 0;
		end else begin
			if (cfg_wr_en)
				gate_count = cfg_wr_data;
			if (m_tvalid && m_tready) begin
				if (owed_words.size() == 0)
					report_mismatch("unexpected result word", m_tdata, 'x);
				else if (m_tdata !== owed_words[0]) begin
					report_mismatch("result_word", m_tdata, owed_words[0]);
					void'(owed_words.pop_front());
				end else
					void'(owed_words.pop_front());
			end
			if (s_tvalid && s_tready) begin
				if (mode_t'(s_tuser) == MODE_LOAD) begin
					gate_target[s_tdata[5:0]] = s_tdata[9:6];
					gate_controls[s_tdata[5:0]] = s_tdata[25:10];
				end else
					owed_words.insert(owed_words.size(), run_cascade(s_tdata[41:26]));
			end
			mismatch_count <= errors;
			results_owed <= owed_words.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and evaluate words into the Toffoli cascade evaluator with
// bursty input and a stalling receiver, steps active_gates through its range
// between phases, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;
	import tce_pkg::*;

	localparam int MAX_GATES       = 64;
	localparam int DRAIN_CYCLES    = MAX_GATES + 4;
	localparam int LONG_HOLD       = 400;
	localparam int STALL_LIMIT     = 3000;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int HOLD_PHASE      = 2;

	typedef enum {RX_OPEN, RX_BUSY, RX_CHOKED} rx_style_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [47:0]       s_tdata = '0;   // gate_slot, target_line, control_mask, data_word
	logic              s_tuser = 1'b0; // mode
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [WORD_W-1:0] m_tdata;        // result_word
	logic              cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]  cfg_wr_data = '0;
	logic              hold_req = 1'b0;

	int mismatch_count;
	int results_owed;
	int burst_left = 0;
	int quiet_cycles = 0;

	int gate_counts [12] = '{64, 1, 127, 0, 65, 16, 64, 100, 33, 2, 127, 48};

	initial begin
		forever #5 clk = ~clk;
	end

	toffoli_cascade_evaluator #(
		.NUM_LINES(16),
		.MAX_GATES(MAX_GATES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	cascade_checker #(
		.MAX_GATES(MAX_GATES)
	) cascade_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.mismatch_count(mismatch_count),
		.results_owed(results_owed)
	);

	// receiver: changing stall styles, plus one long hold-off on request
	initial begin
		rx_style_t style;
		int style_left;
		int hold_left;
		bit hold_done;
		style = RX_OPEN;
		style_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					style = rx_style_t'($urandom_range(0, 2));
					style_left = $urandom_range(10, 150);
				end
				style_left--;
				case (style)
					RX_OPEN:   m_tready <= 1'b1;
					RX_BUSY:   m_tready <= ($urandom_range(0, 3) != 0);
					default:   m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic logic [WORD_W-1:0] pick_controls();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return WORD_W'(16'h0001 << $urandom_range(0, 15));
			2: return WORD_W'($urandom & $urandom & $urandom);
			3: return WORD_W'($urandom & $urandom);
			default: return WORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_lines();
		case ($urandom_range(0, 3))
			0: return WORD_W'($urandom);
			1: return 16'hFFFF;
			default: return WORD_W'($urandom | $urandom);
		endcase
	endfunction

	task automatic push_word(input mode_t mode, input logic [SLOT_W-1:0] slot,
			input logic [TGT_W-1:0] target, input logic [WORD_W-1:0] controls,
			input logic [WORD_W-1:0] lines);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {6'b0, lines, controls, target, slot};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	task automatic load_gate(input logic [SLOT_W-1:0] slot, input logic [TGT_W-1:0] target,
			input logic [WORD_W-1:0] controls);
		push_word(MODE_LOAD, slot, target, controls, WORD_W'($urandom));
	endtask

	task automatic eval_word(input logic [WORD_W-1:0] lines);
		push_word(MODE_EVAL, SLOT_W'($urandom), TGT_W'($urandom), WORD_W'($urandom), lines);
	endtask

	// stop sending, let every owed word arrive and loads leave the pipe
	task automatic settle();
		s_tvalid <= 1'b0;
		while (results_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic set_gates(input logic [CFG_W-1:0] count);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= count;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no active gates: words pass through
		eval_word(16'h0000);
		eval_word(16'hFFFF);
		load_gate(6'd0, 4'd15, 16'h0000);  // plain NOT on the top line
		load_gate(6'd1, 4'd0, 16'hFFFF);   // every line a control, target included
		load_gate(6'd2, 4'd7, 16'h8001);
		load_gate(6'd3, 4'd4, 16'h0010);   // control sits on its own target
		load_gate(6'd63, 4'd15, 16'hFFFF);
		settle();
		set_gates(7'd4);
		eval_word(16'h0000);
		eval_word(16'hFFFF);
		eval_word(16'h7FFF);
		eval_word(16'h7FFE);
		eval_word(16'h8001);
		eval_word(16'h0010);
		eval_word(16'hAAAA);
		eval_word(16'h5555);
		eval_word(16'h7F7F);
		settle();

		for (int s = 0; s < MAX_GATES; s++)
			load_gate(SLOT_W'(s), TGT_W'($urandom_range(0, 15)), pick_controls());

		foreach (gate_counts[p]) begin
			settle();
			set_gates(CFG_W'(gate_counts[p]));
			if (p == HOLD_PHASE)
				hold_req <= 1'b1;
			repeat (ITEMS_PER_PHASE) begin
				if (p != HOLD_PHASE && $urandom_range(0, 4) == 0)
					load_gate(SLOT_W'($urandom_range(0, MAX_GATES - 1)),
						TGT_W'($urandom_range(0, 15)), pick_controls());
				else
					eval_word(pick_lines());
			end
		end
		settle();

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
